// File: hw/rtl/stcs_pkg.sv
`default_nettype none

package stcs_pkg;

   localparam int SEED_W  = 64;
   localparam int RADIX_W = 9;
   localparam int LEN_W   = 5;
   localparam int POS_W   = 4;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 8;
   localparam int RESULT_CAP = 16;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_GENERATE = 1'b1;

   localparam logic REG_SYMBOL_COUNT = 1'b0;
   localparam logic REG_TEXT_LENGTH  = 1'b1;

   localparam logic [RADIX_W-1:0] SYMBOL_COUNT_RESET = 9'd2;
   localparam logic [LEN_W-1:0]   TEXT_LENGTH_RESET  = 5'd8;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] entry_index;
      logic [CHAR_W-1:0]  entry_char;
      logic [SEED_W-1:0]  first_seed;
      logic [SEED_W-1:0]  second_seed;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic [POS_W-1:0]  char_position;
      logic              last_char;
   } rsp_type;

   typedef struct packed {
      logic [SEED_W-1:0]  quotient;
      logic [RADIX_W-1:0] remainder;
   } div_result_type;

endpackage

`default_nettype wire

// File: hw/rtl/stcs_divider.sv
`default_nettype none

module stcs_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [stcs_pkg::SEED_W-1:0]   dividend,
   input  wire logic [stcs_pkg::RADIX_W-1:0]  divisor,
   output logic                               done,
   output stcs_pkg::div_result_type           result
);

   localparam int CNT_W = $clog2(stcs_pkg::SEED_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [stcs_pkg::SEED_W-1:0]   quo_ff, quo_in;
   logic [stcs_pkg::RADIX_W-1:0]  rem_ff, rem_in;
   logic [stcs_pkg::RADIX_W-1:0]  divisor_ff, divisor_in;
   logic [stcs_pkg::RADIX_W:0]    rem_shift;
   logic [stcs_pkg::RADIX_W:0]    rem_diff;
   logic                          fits;

   // one quotient bit per cycle, msb first
   always_comb begin
      rem_shift = {rem_ff, quo_ff[stcs_pkg::SEED_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = rem_shift >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(stcs_pkg::SEED_W - 1);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[stcs_pkg::SEED_W-2:0], fits};
         rem_in   = fits ? rem_diff[stcs_pkg::RADIX_W-1:0]
                         : rem_shift[stcs_pkg::RADIX_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done             = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

`default_nettype wire

// File: hw/rtl/stcs_symbol_ram.sv
`default_nettype none

module stcs_symbol_ram #(
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [AW-1:0]                wr_addr,
   input  wire logic [stcs_pkg::CHAR_W-1:0]  wr_data,
   input  wire logic                         rd_en,
   input  wire logic [AW-1:0]                rd_addr,
   output logic [stcs_pkg::CHAR_W-1:0]       rd_data
);

   logic [stcs_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [stcs_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/seed_to_charset_string_unit.sv
// channel   direction  payload               transfer when
// req       in         stcs_pkg::req_type    req_valid && !req_stall
// rsp       out        stcs_pkg::rsp_type    rsp_valid && !rsp_stall
// csr       in         index, 9-bit data     csr_write_enable
//
// a load writes the symbol table entry it names; a generate produces each character with
// a 64-bit bit-serial division, a result step and a table read, in that order
// reset is synchronous; the symbol table is not cleared
// req is stalled while a string is being produced; a stalled rsp holds the
// sequencer in its emit step until the pending character is taken
`default_nettype none

module seed_to_charset_string_unit #(
   parameter int MAX_TEXT_LEN = 16,
   parameter int TABLE_DEPTH  = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire stcs_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output stcs_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [stcs_pkg::RADIX_W-1:0]  csr_write_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LEN_CAP = (MAX_TEXT_LEN < stcs_pkg::RESULT_CAP) ? MAX_TEXT_LEN
                                                                  : stcs_pkg::RESULT_CAP;
   localparam logic [stcs_pkg::RADIX_W-1:0] DEPTH_RADIX = stcs_pkg::RADIX_W'(TABLE_DEPTH);
   localparam logic [stcs_pkg::RADIX_W-1:0] ADDR_MASK =
      stcs_pkg::RADIX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [stcs_pkg::RADIX_W-1:0]    symbol_count_ff, symbol_count_in;
   logic [stcs_pkg::LEN_W-1:0]      text_length_ff, text_length_in;
   logic [stcs_pkg::RADIX_W-1:0]    radix_ff, radix_in;
   logic [stcs_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [stcs_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [stcs_pkg::SEED_W-1:0]     value_ff, value_in;
   logic [stcs_pkg::SEED_W-1:0]     reload_ff, reload_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   stcs_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic [stcs_pkg::RADIX_W-1:0]    radix_clamped;
   logic [stcs_pkg::LEN_W-1:0]      len_clamped;
   logic                            div_start;
   logic [stcs_pkg::SEED_W-1:0]     div_dividend;
   logic                            div_done;
   stcs_pkg::div_result_type        div_result;
   logic [stcs_pkg::RADIX_W-1:0]    rem_masked;
   logic                            ram_wr_en;
   logic                            ram_rd_en;
   logic [stcs_pkg::CHAR_W-1:0]     ram_rd_data;
   logic                            last_step;
   logic                            out_free;

   always_comb begin
      symbol_count_in = symbol_count_ff;
      text_length_in  = text_length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            stcs_pkg::REG_SYMBOL_COUNT: symbol_count_in = csr_write_data;
            stcs_pkg::REG_TEXT_LENGTH:  text_length_in  = csr_write_data[stcs_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      radix_clamped = symbol_count_ff;
      if (symbol_count_ff < 9'd2) begin
         radix_clamped = 9'd2;
      end else if (symbol_count_ff > DEPTH_RADIX) begin
         radix_clamped = DEPTH_RADIX;
      end
      len_clamped = text_length_ff;
      if (text_length_ff > stcs_pkg::LEN_W'(LEN_CAP)) begin
         len_clamped = stcs_pkg::LEN_W'(LEN_CAP);
      end
   end

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign ram_wr_en  = req_accept && req_data.command == stcs_pkg::CMD_LOAD
                       && {1'b0, req_data.entry_index} < DEPTH_RADIX;
   assign rem_masked = div_result.remainder & ADDR_MASK;
   assign last_step  = ({1'b0, pos_ff} + 5'd1) == len_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      reload_in    = reload_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = value_ff;
      ram_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.command == stcs_pkg::CMD_GENERATE) begin
               radix_in  = radix_clamped;
               len_in    = len_clamped;
               pos_in    = '0;
               reload_in = req_data.second_seed;
               if (len_clamped != '0) begin
                  div_start    = 1'b1;
                  div_dividend = req_data.first_seed;
                  state_in     = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               ram_rd_en = 1'b1;
               value_in  = (div_result.quotient < {55'd0, radix_ff}) ? reload_ff
                                                                   : div_result.quotient;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_char      = ram_rd_data;
               rsp_data_in.char_position = pos_ff;
               rsp_data_in.last_char     = last_step;
               if (last_step) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in    = pos_ff + 1'b1;
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         symbol_count_ff <= stcs_pkg::SYMBOL_COUNT_RESET;
         text_length_ff  <= stcs_pkg::TEXT_LENGTH_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         symbol_count_ff <= symbol_count_in;
         text_length_ff  <= text_length_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      reload_ff   <= reload_in;
      rsp_data_ff <= rsp_data_in;
   end

   stcs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_in),
      .done     (div_done),
      .result   (div_result)
   );

   stcs_symbol_ram #(
      .DEPTH (TABLE_DEPTH)
   ) u_symbol_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_data.entry_index[AW-1:0]),
      .wr_data (req_data.entry_char),
      .rd_en   (ram_rd_en),
      .rd_addr (rem_masked[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
